// ===== design/smoothed_tilt_limit_drive_control_assert.svh =====
// Assertion macros for the top-level design file.
`ifndef SMOOTHED_TILT_LIMIT_DRIVE_CONTROL_ASSERT_SVH
`define SMOOTHED_TILT_LIMIT_DRIVE_CONTROL_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Condition holds at every clock edge out of reset
`define STDLC_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("%m: invariant violated");
// Same-cycle implication
`define STDLC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: implication violated");
// Next-cycle implication
`define STDLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication violated");
`else
`define STDLC_ASSERT_ALWAYS(label, expr)
`define STDLC_ASSERT_IMPL(label, ante, cons)
`define STDLC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/stdlc_pkg.sv =====
package stdlc_pkg;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int VALUE_W  = 13;
    localparam int CFG_IDX_W = 4;

    // Reciprocal scaling used for the per-sample quotient
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 20;
    localparam int PROD_W      = SAMPLE_W + RECIP_W;

    // Register reset values
    localparam logic signed [VALUE_W-1:0] OPEN_LIMIT_RST  = 13'sd600;
    localparam logic signed [VALUE_W-1:0] CLOSE_LIMIT_RST = 13'sd980;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LIMIT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_LIMIT = 4'd1;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_OPEN    = 2'd1,
        OP_CLOSE   = 2'd2,
        OP_PRELOAD = 2'd3
    } op_t;

    // Drive codes
    typedef enum logic [1:0] {
        DRIVE_STOP  = 2'd0,
        DRIVE_OPEN  = 2'd1,
        DRIVE_CLOSE = 2'd2
    } drive_t;

    // Motion mode, one-hot
    typedef enum logic [2:0] {
        MODE_DONE    = 3'b001,
        MODE_OPENING = 3'b010,
        MODE_CLOSING = 3'b100
    } mode_t;

    // Mode codes as reported on the result channel
    localparam logic [1:0] MODE_CODE_DONE    = 2'd0;
    localparam logic [1:0] MODE_CODE_OPENING = 2'd1;
    localparam logic [1:0] MODE_CODE_CLOSING = 2'd2;

    // Front stage to update stage
    typedef struct packed {
        op_t                        op;
        logic signed [VALUE_W-1:0]  quot;
    } front_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] c;
        case (m)
            MODE_OPENING: c = MODE_CODE_OPENING;
            MODE_CLOSING: c = MODE_CODE_CLOSING;
            default:      c = MODE_CODE_DONE;
        endcase
        return c;
    endfunction

endpackage

// ===== design/smoothed_tilt_limit_drive_control.sv =====
// An accepted input beat passes through the front register, then the state
// registers that drive the result ports, before its result beat is valid.
// Throughput: one beat per cycle while the result channel is not stalled, set by
// the running-sum and mode update at the end of the quotient delay line.
// Reset (aresetn low, synchronous): delay line and average cleared, mode done,
// drive stop, power off, limits back to 600 and 980.
module smoothed_tilt_limit_drive_control #(
    parameter int WINDOW_TAPS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_op,
    input  logic signed [stdlc_pkg::SAMPLE_W-1:0]  s_tilt_sample,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [stdlc_pkg::VALUE_W-1:0]   m_smoothed_value,
    output logic [1:0]                             m_drive_code,
    output logic                                   m_power_on,
    output logic [1:0]                             m_mode_now,
    // configuration channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [stdlc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [stdlc_pkg::VALUE_W-1:0]          cfg_data
);

    `include "smoothed_tilt_limit_drive_control_assert.svh"

    logic                                  front_valid;
    stdlc_pkg::front_t                     front;
    logic                                  advance;
    logic                                  fire;
    logic                                  push;
    logic                                  done_tick;
    logic signed [stdlc_pkg::VALUE_W-1:0]  tap [WINDOW_TAPS];
    logic signed [stdlc_pkg::VALUE_W-1:0]  sum_push;

    logic signed [stdlc_pkg::VALUE_W-1:0]  open_limit_reg, open_limit_next;
    logic signed [stdlc_pkg::VALUE_W-1:0]  close_limit_reg, close_limit_next;
    logic signed [stdlc_pkg::VALUE_W-1:0]  avg_reg, avg_next;
    stdlc_pkg::mode_t                      mode_reg, mode_next;
    stdlc_pkg::drive_t                     drive_reg, drive_next;
    logic                                  power_reg, power_next;
    logic                                  m_valid_reg, m_valid_next;

    // handshakes
    assign advance   = !m_valid_reg || m_ready;
    assign fire      = front_valid && advance;
    assign s_ready   = !front_valid || advance;
    assign cfg_ready = 1'b1;

    stdlc_front #(
        .WINDOW_TAPS (WINDOW_TAPS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (s_valid && s_ready),
        .advance     (advance),
        .op          (stdlc_pkg::op_t'(s_op)),
        .tilt_sample (s_tilt_sample),
        .valid       (front_valid),
        .front       (front)
    );

    // a beat pushes on preload, or on a tick while a move is in progress
    assign push = fire && ((front.op == stdlc_pkg::OP_PRELOAD) ||
                           ((front.op == stdlc_pkg::OP_TICK) &&
                            (mode_reg != stdlc_pkg::MODE_DONE)));

    // tick taken while no move is in progress
    assign done_tick = fire && (front.op == stdlc_pkg::OP_TICK) &&
                       (mode_reg == stdlc_pkg::MODE_DONE);

    // quotient delay line
    for (genvar i = 0; i < WINDOW_TAPS; i++) begin : g_cell
        stdlc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (push),
            .d_in     ((i == 0) ? front.quot : tap[(i == 0) ? 0 : i-1]),
            .q_out    (tap[i])
        );
    end

    // running sum: add the new quotient, drop the oldest
    assign sum_push = avg_reg + front.quot - tap[WINDOW_TAPS-1];

    // configuration writes
    always_comb begin
        open_limit_next  = open_limit_reg;
        close_limit_next = close_limit_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == stdlc_pkg::CFG_OPEN_LIMIT) begin
                open_limit_next = $signed(cfg_data);
            end else if (cfg_index == stdlc_pkg::CFG_CLOSE_LIMIT) begin
                close_limit_next = $signed(cfg_data);
            end
        end
    end

    // mode, drive and power update
    always_comb begin
        avg_next   = avg_reg;
        mode_next  = mode_reg;
        drive_next = drive_reg;
        power_next = power_reg;
        if (push) begin
            avg_next = sum_push;
        end
        if (fire) begin
            case (front.op)
                stdlc_pkg::OP_TICK: begin
                    case (mode_reg)
                        stdlc_pkg::MODE_OPENING: begin
                            if (sum_push > open_limit_reg) begin
                                drive_next = stdlc_pkg::DRIVE_OPEN;
                                power_next = 1'b1;
                            end else begin
                                mode_next = stdlc_pkg::MODE_DONE;
                            end
                        end
                        stdlc_pkg::MODE_CLOSING: begin
                            if (sum_push < close_limit_reg) begin
                                drive_next = stdlc_pkg::DRIVE_CLOSE;
                                power_next = 1'b1;
                            end else begin
                                mode_next = stdlc_pkg::MODE_DONE;
                            end
                        end
                        default: begin
                            drive_next = stdlc_pkg::DRIVE_STOP;
                            power_next = 1'b0;
                        end
                    endcase
                end
                stdlc_pkg::OP_OPEN:  mode_next = stdlc_pkg::MODE_OPENING;
                stdlc_pkg::OP_CLOSE: mode_next = stdlc_pkg::MODE_CLOSING;
                default: begin
                end
            endcase
        end
    end

    // result valid: state only moves on fire, so the ports hold while stalled
    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_limit_reg  <= stdlc_pkg::OPEN_LIMIT_RST;
            close_limit_reg <= stdlc_pkg::CLOSE_LIMIT_RST;
            avg_reg         <= '0;
            mode_reg        <= stdlc_pkg::MODE_DONE;
            drive_reg       <= stdlc_pkg::DRIVE_STOP;
            power_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            open_limit_reg  <= open_limit_next;
            close_limit_reg <= close_limit_next;
            avg_reg         <= avg_next;
            mode_reg        <= mode_next;
            drive_reg       <= drive_next;
            power_reg       <= power_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // result ports
    assign m_valid          = m_valid_reg;
    assign m_smoothed_value = avg_reg;
    assign m_drive_code     = drive_reg;
    assign m_power_on       = power_reg;
    assign m_mode_now       = stdlc_pkg::mode_code(mode_reg);

    // checks
    `STDLC_ASSERT_ALWAYS(a_power_tracks_drive, power_reg == (drive_reg != stdlc_pkg::DRIVE_STOP))
    `STDLC_ASSERT_ALWAYS(a_avg_in_range, (avg_reg <= 13'sd2048) && (avg_reg >= -13'sd2048))
    `STDLC_ASSERT_NEXT(a_accept_fills_front, s_valid && s_ready, front_valid)
    `STDLC_ASSERT_NEXT(a_done_tick_stops, done_tick, !power_reg && m_valid)

endmodule

// ===== design/stdlc_cell.sv =====
// One tap of the quotient delay line
module stdlc_cell (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  shift_en,
    input  logic signed [stdlc_pkg::VALUE_W-1:0]  d_in,
    output logic signed [stdlc_pkg::VALUE_W-1:0]  q_out
);

    logic signed [stdlc_pkg::VALUE_W-1:0] q_reg;
    logic signed [stdlc_pkg::VALUE_W-1:0] q_next;

    // take the neighbor's value on a push
    always_comb begin
        q_next = shift_en ? d_in : q_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= '0;
        end else begin
            q_reg <= q_next;
        end
    end

    assign q_out = q_reg;

endmodule

// ===== design/stdlc_front.sv =====
// Front stage: negate the sample and form its truncated quotient by the window
module stdlc_front #(
    parameter int WINDOW_TAPS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   load,
    input  logic                                   advance,
    input  stdlc_pkg::op_t                         op,
    input  logic signed [stdlc_pkg::SAMPLE_W-1:0]  tilt_sample,
    output logic                                   valid,
    output stdlc_pkg::front_t                      front
);

    // ceil(2^S / N); exact floor(x/N) for |x| <= 2048 and 2 <= N <= 64
    localparam logic [stdlc_pkg::RECIP_W-1:0] RECIP =
        stdlc_pkg::RECIP_W'(((64'd1 << stdlc_pkg::RECIP_SHIFT) + 64'(WINDOW_TAPS) - 64'd1)
                            / 64'(WINDOW_TAPS));

    logic                                   valid_reg;
    logic                                   valid_next;
    stdlc_pkg::front_t                      front_reg;
    stdlc_pkg::front_t                      front_next;
    logic signed [stdlc_pkg::VALUE_W-1:0]   wide_sample;
    logic signed [stdlc_pkg::VALUE_W-1:0]   abs13;
    logic [stdlc_pkg::VALUE_W-1:0]          mag;
    logic [stdlc_pkg::PROD_W-1:0]           prod;
    logic [stdlc_pkg::VALUE_W-1:0]          qmag;
    logic                                   neg_result;

    // magnitude of the sample (up to 2048); the negated value is negative when
    // the raw one is positive
    always_comb begin
        wide_sample = stdlc_pkg::VALUE_W'(tilt_sample);
        abs13       = tilt_sample[stdlc_pkg::SAMPLE_W-1] ? -wide_sample : wide_sample;
        mag         = $unsigned(abs13);
        neg_result  = !tilt_sample[stdlc_pkg::SAMPLE_W-1] && (tilt_sample != '0);
        prod        = stdlc_pkg::PROD_W'(mag) * stdlc_pkg::PROD_W'(RECIP);
        qmag        = stdlc_pkg::VALUE_W'(prod >> stdlc_pkg::RECIP_SHIFT);
    end

    // stage register
    always_comb begin
        front_next = front_reg;
        valid_next = valid_reg;
        if (load) begin
            front_next.op   = op;
            front_next.quot = neg_result ? -$signed(qmag) : $signed(qmag);
            valid_next      = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        front_reg <= front_next;
    end

    assign valid = valid_reg;
    assign front = front_reg;

endmodule
